[hw/rtl/usrm_pkg.sv]
// usrm_pkg: shared constants, codes and types of the URL scope rule matcher.
// No dependencies; usrm_queue, usrm_front, usrm_back and the top level import it.
`default_nettype none

package usrm_pkg;

	// Table and buffer sizes
	localparam int RULES        = 64;
	localparam int DOMAIN_BYTES = 256;
	localparam int PATH_BYTES   = 512;
	localparam int URL_BYTES    = 1024;

	localparam int RIDX_W    = (RULES > 1) ? $clog2(RULES) : 1;
	localparam int CNT_W     = $clog2(RULES + 1);
	localparam int DLEN_W    = $clog2(DOMAIN_BYTES);
	localparam int PLEN_W    = $clog2(PATH_BYTES);
	localparam int HLEN_W    = DLEN_W + 1;
	localparam int TOT_W     = $clog2(URL_BYTES + 2);
	localparam int DOM_AW    = RIDX_W + DLEN_W;
	localparam int PTH_AW    = RIDX_W + PLEN_W;
	localparam int DOM_DEPTH = 2 ** DOM_AW;
	localparam int PTH_DEPTH = 2 ** PTH_AW;
	localparam int HOST_DEPTH = 2 ** DLEN_W;
	localparam int UP_DEPTH   = 2 ** PLEN_W;
	localparam int META_DEPTH = 2 ** RIDX_W;

	// Characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CASE_OFS = 8'h20;

	localparam logic [6:0] NO_RULE = 7'h7F;

	typedef enum logic [2:0] {
		OP_DOM_BYTE  = 3'd0,
		OP_PATH_BYTE = 3'd1,
		OP_COMMIT    = 3'd2,
		OP_LOCK      = 3'd3,
		OP_URL_BYTE  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		KIND_DOM_EXACT   = 3'd0,
		KIND_WILDCARD    = 3'd1,
		KIND_PATH_PREFIX = 3'd2,
		KIND_PATH_EXACT  = 3'd3,
		KIND_URL_PATTERN = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_IN_SCOPE  = 2'd0,
		ST_OUT_SCOPE = 2'd1,
		ST_NOT_SET   = 2'd2,
		ST_INVALID   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		PH_SCAN, PH_COLON, PH_SLASH, PH_HOST, PH_PATH,
		PH_END_SCAN, PH_END_HOST, PH_END_PATH
	} phase_t;

	typedef enum logic [3:0] {
		B_IDLE, B_META, B_HDR, B_HDR2, B_HDR3, B_CADDR, B_CCHK,
		B_PSET, B_MISS, B_HIT, B_OUT
	} back_state_t;

	// Per-rule descriptor
	typedef struct packed {
		logic [2:0]        kind;
		logic [DLEN_W-1:0] dlen;
		logic [PLEN_W-1:0] plen;
	} meta_t;

	localparam int META_W = $bits(meta_t);

	// Job handed from front to back
	typedef struct packed {
		logic              is_verdict;
		logic              accepted;
		logic              walk;
		status_t           status;
		logic [CNT_W-1:0]  count;
		logic [DLEN_W-1:0] hlen;
		logic [PLEN_W-1:0] plen;
	} job_t;

	typedef struct packed {
		logic             busy;
		logic [CNT_W-1:0] count;
	} front_stat_t;

endpackage

`default_nettype wire

[hw/rtl/usrm_in_if.sv]
// usrm_in_if: request channel (valid/ready plus item fields).
// No dependencies.
`default_nettype none

interface usrm_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] op;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       last;
	logic [2:0] rule_kind;
	logic       approved;

	modport source (output valid, op, data_byte, byte_present, last, rule_kind, approved,
		input ready);
	modport sink (input valid, op, data_byte, byte_present, last, rule_kind, approved,
		output ready);
endinterface

`default_nettype wire

[hw/rtl/usrm_out_if.sv]
// usrm_out_if: result channel (valid/ready plus result fields).
// No dependencies.
`default_nettype none

interface usrm_out_if;
	logic              valid;
	logic              ready;
	logic              result_kind;
	logic              accepted;
	logic [1:0]        status;
	logic              allowed;
	logic signed [6:0] matched_rule;

	modport source (output valid, result_kind, accepted, status, allowed, matched_rule,
		input ready);
	modport sink (input valid, result_kind, accepted, status, allowed, matched_rule,
		output ready);
endinterface

`default_nettype wire

[hw/rtl/usrm_ram.sv]
// usrm_ram: generic simple dual-port RAM, one write port, registered read.
// No dependencies.
`default_nettype none

module usrm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[hw/rtl/usrm_queue.sv]
// usrm_queue: two-entry job queue between front and back.
// Depends on usrm_pkg (job_t).
`default_nettype none

module usrm_queue import usrm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      push_data,
	input  wire logic pop,
	output job_t      head,
	output logic      empty,
	output logic      full
);

	job_t       ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign head  = ent_q[rp_q];
	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[hw/rtl/usrm_front.sv]
// usrm_front: accepts beats, stages and commits rules, parses URL bytes and
// queues commit answers and verdict jobs. Depends on usrm_pkg, usrm_in_if.
`default_nettype none

module usrm_front import usrm_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	usrm_in_if.sink           req,
	input  wire logic         q_full,
	output logic              q_push,
	output job_t              q_data,
	input  wire logic         walk_done,
	output logic              dom_we,
	output logic [DOM_AW-1:0] dom_waddr,
	output logic [7:0]        dom_wdata,
	output logic              pth_we,
	output logic [PTH_AW-1:0] pth_waddr,
	output logic [7:0]        pth_wdata,
	output logic              meta_we,
	output logic [RIDX_W-1:0] meta_waddr,
	output meta_t             meta_wdata,
	output logic              host_we,
	output logic [DLEN_W-1:0] host_waddr,
	output logic [7:0]        host_wdata,
	output logic              up_we,
	output logic [PLEN_W-1:0] up_waddr,
	output logic [7:0]        up_wdata,
	output front_stat_t       stat
);

	// Rule table state
	logic [CNT_W-1:0]  count_q;
	logic              locked_q;
	logic [DLEN_W-1:0] sdlen_q;
	logic [PLEN_W-1:0] splen_q;
	logic              dz_q;
	logic [DLEN_W-1:0] deff_q;
	logic              pz_q;
	logic [PLEN_W-1:0] peff_q;
	// URL parser state
	phase_t            ph_q;
	logic [TOT_W-1:0]  total_q;
	logic [HLEN_W-1:0] hlen_q;
	logic [PLEN_W-1:0] uplen_q;
	logic              busy_q;

	logic              acc;
	logic              has_slot;
	logic              stage_d;
	logic              stage_p;
	logic              commit_ok;
	logic              u_byte;
	logic              c_zero;
	logic              ended;
	logic [7:0]        c;
	logic [7:0]        c_low;
	phase_t            n_ph;
	logic [TOT_W-1:0]  n_tot;
	logic [HLEN_W-1:0] n_h;
	logic [PLEN_W-1:0] n_p;
	logic              verdict;
	logic              v_walk;
	status_t           v_status;
	logic              has_path;

	assign c        = req.data_byte;
	assign acc      = req.valid && req.ready;
	assign req.ready = !q_full && !busy_q;
	assign has_slot = count_q < CNT_W'(RULES);
	assign stage_d  = acc && (req.op == OP_DOM_BYTE) && has_slot &&
		(sdlen_q != DLEN_W'(DOMAIN_BYTES - 1));
	assign stage_p  = acc && (req.op == OP_PATH_BYTE) && has_slot &&
		(splen_q != PLEN_W'(PATH_BYTES - 1));
	assign commit_ok = !locked_q && has_slot && req.approved;
	assign ended    = (ph_q == PH_END_SCAN) || (ph_q == PH_END_HOST) || (ph_q == PH_END_PATH);
	assign u_byte   = acc && (req.op == OP_URL_BYTE) && req.byte_present && !ended;
	assign c_zero   = (c == CH_NUL);
	assign c_low    = (c >= CH_UP_A && c <= CH_UP_Z) ? (c + CASE_OFS) : c;
	assign verdict  = acc && (req.op == OP_URL_BYTE) && req.last;

	// Staging writes go straight into the next rule's slot
	assign dom_we    = stage_d;
	assign dom_waddr = {count_q[RIDX_W-1:0], sdlen_q};
	assign dom_wdata = c;
	assign pth_we    = stage_p;
	assign pth_waddr = {count_q[RIDX_W-1:0], splen_q};
	assign pth_wdata = c;

	// Commit writes the descriptor, length cut at the first zero byte
	assign meta_we         = acc && (req.op == OP_COMMIT) && commit_ok;
	assign meta_waddr      = count_q[RIDX_W-1:0];
	assign meta_wdata.kind = req.rule_kind;
	assign meta_wdata.dlen = dz_q ? deff_q : sdlen_q;
	assign meta_wdata.plen = pz_q ? peff_q : splen_q;

	// Parser phase: next state
	always_comb begin
		n_ph = ph_q;
		if (u_byte) begin
			if (c_zero) begin
				unique case (ph_q)
					PH_HOST: n_ph = PH_END_HOST;
					PH_PATH: n_ph = PH_END_PATH;
					default: n_ph = PH_END_SCAN;
				endcase
			end else begin
				unique case (ph_q)
					PH_HOST: if (c == CH_SLASH) n_ph = PH_PATH;
					PH_PATH: n_ph = PH_PATH;
					default: begin
						priority if (c == CH_COLON)                       n_ph = PH_COLON;
						else if (c == CH_SLASH && ph_q == PH_COLON)       n_ph = PH_SLASH;
						else if (c == CH_SLASH && ph_q == PH_SLASH)       n_ph = PH_HOST;
						else                                              n_ph = PH_SCAN;
					end
				endcase
			end
		end
	end

	// Parser outputs: counters and buffer writes
	always_comb begin
		n_tot      = total_q;
		n_h        = hlen_q;
		n_p        = uplen_q;
		host_we    = 1'b0;
		host_waddr = hlen_q[DLEN_W-1:0];
		host_wdata = c_low;
		up_we      = 1'b0;
		up_waddr   = '0;
		up_wdata   = CH_SLASH;
		if (u_byte && !c_zero) begin
			if (total_q <= TOT_W'(URL_BYTES)) n_tot = total_q + TOT_W'(1);
			unique case (ph_q)
				PH_HOST: begin
					if (c == CH_SLASH) begin
						up_we = 1'b1;
						n_p   = PLEN_W'(1);
					end else if (hlen_q < HLEN_W'(DOMAIN_BYTES)) begin
						host_we = 1'b1;
						n_h     = hlen_q + HLEN_W'(1);
					end
				end
				PH_PATH: begin
					if (uplen_q < PLEN_W'(PATH_BYTES - 1)) begin
						up_we    = 1'b1;
						up_waddr = uplen_q;
						up_wdata = c;
						n_p      = uplen_q + PLEN_W'(1);
					end
				end
				default: begin
					// seed the root path when the authority starts
					up_we = (c == CH_SLASH) && (ph_q == PH_SLASH);
				end
			endcase
		end
	end

	// Verdict triage from the updated parser state
	assign has_path = (n_ph == PH_PATH) || (n_ph == PH_END_PATH);
	always_comb begin
		v_walk   = 1'b0;
		v_status = ST_INVALID;
		priority if (n_tot == '0 || n_tot > TOT_W'(URL_BYTES)) begin
			v_status = ST_INVALID;
		end else if (count_q == '0) begin
			v_status = ST_NOT_SET;
		end else if (!(has_path || n_ph == PH_HOST || n_ph == PH_END_HOST) ||
			n_h == '0 || n_h >= HLEN_W'(DOMAIN_BYTES)) begin
			v_status = ST_INVALID;
		end else begin
			v_walk = 1'b1;
		end
	end

	// Queue push
	always_comb begin
		q_push            = acc && ((req.op == OP_COMMIT) || verdict);
		q_data.is_verdict = (req.op == OP_URL_BYTE);
		q_data.accepted   = (req.op == OP_COMMIT) && commit_ok;
		q_data.walk       = verdict && v_walk;
		q_data.status     = verdict ? v_status : ST_IN_SCOPE;
		q_data.count      = count_q;
		q_data.hlen       = n_h[DLEN_W-1:0];
		q_data.plen       = has_path ? n_p : PLEN_W'(1);
	end

	assign stat.busy  = busy_q;
	assign stat.count = count_q;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			locked_q <= 1'b0;
			sdlen_q  <= '0;
			splen_q  <= '0;
			dz_q     <= 1'b0;
			deff_q   <= '0;
			pz_q     <= 1'b0;
			peff_q   <= '0;
			ph_q     <= PH_SCAN;
			total_q  <= '0;
			hlen_q   <= '0;
			uplen_q  <= '0;
			busy_q   <= 1'b0;
		end else begin
			if (stage_d) begin
				sdlen_q <= sdlen_q + DLEN_W'(1);
				if (!dz_q && c_zero) begin
					dz_q   <= 1'b1;
					deff_q <= sdlen_q;
				end
			end
			if (stage_p) begin
				splen_q <= splen_q + PLEN_W'(1);
				if (!pz_q && c_zero) begin
					pz_q   <= 1'b1;
					peff_q <= splen_q;
				end
			end
			if (acc && req.op == OP_COMMIT) begin
				if (commit_ok) count_q <= count_q + CNT_W'(1);
				sdlen_q <= '0;
				splen_q <= '0;
				dz_q    <= 1'b0;
				pz_q    <= 1'b0;
			end
			if (acc && req.op == OP_LOCK) begin
				locked_q <= 1'b1;
			end
			// parser returns to reset after each verdict
			if (verdict) begin
				ph_q    <= PH_SCAN;
				total_q <= '0;
				hlen_q  <= '0;
				uplen_q <= '0;
			end else begin
				ph_q    <= n_ph;
				total_q <= n_tot;
				hlen_q  <= n_h;
				uplen_q <= n_p;
			end
			// URL buffers are held until the back finishes its walk
			if (verdict && v_walk) busy_q <= 1'b1;
			else if (walk_done)    busy_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/usrm_back.sv]
// usrm_back: pops jobs, walks the rule table byte by byte for verdicts and
// drives the result register. Depends on usrm_pkg, usrm_out_if.
`default_nettype none

module usrm_back import usrm_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  job_t              head,
	input  wire logic         q_empty,
	output logic              q_pop,
	output logic              walk_done,
	output logic [RIDX_W-1:0] meta_raddr,
	input  wire logic [META_W-1:0] meta_rdata,
	output logic [DOM_AW-1:0] dom_raddr,
	input  wire logic [7:0]   dom_rdata,
	output logic [PTH_AW-1:0] pth_raddr,
	input  wire logic [7:0]   pth_rdata,
	output logic [DLEN_W-1:0] host_raddr,
	input  wire logic [7:0]   host_rdata,
	output logic [PLEN_W-1:0] up_raddr,
	input  wire logic [7:0]   up_rdata,
	usrm_out_if.source        rsp
);

	back_state_t       state_q, nxt;
	job_t              job_q;
	logic [RIDX_W-1:0] r_q;
	logic [2:0]        typ_q;
	logic [DLEN_W-1:0] rdlen_q;
	logic [PLEN_W-1:0] rplen_q;
	logic [7:0]        d0_q;
	logic              star_q;
	logic [PLEN_W-1:0] i_q;
	logic [PLEN_W-1:0] clen_q;
	logic              roff_q;
	logic [DLEN_W-1:0] hoff_q;
	logic              pmode_q;
	status_t           res_q;

	logic              out_vld_q;
	logic              out_kind_q;
	logic              out_acc_q;
	status_t           out_status_q;
	logic              out_allowed_q;
	logic [6:0]        out_rule_q;

	meta_t             meta;
	logic              out_free;
	logic              out_load;
	logic              ld_kind, ld_acc, ld_allowed;
	status_t           ld_status;
	logic [6:0]        ld_rule;
	logic              dom_kinds_exact, dom_kinds_wild, path_kinds, prefix_kinds;
	logic              wild, dom_suffix, dom_fail;
	logic [DLEN_W-1:0] slen;
	logic [PLEN_W-1:0] pn1;
	logic              pstar, path_fail;
	logic              cmp_end, byte_eq, last_rule;

	assign meta     = meta_t'(meta_rdata);
	assign out_free = !out_vld_q || rsp.ready;

	// Rule classification
	assign dom_kinds_exact = (typ_q == KIND_DOM_EXACT) || (typ_q == KIND_PATH_PREFIX) ||
		(typ_q == KIND_PATH_EXACT);
	assign dom_kinds_wild  = (typ_q == KIND_WILDCARD) || (typ_q == KIND_URL_PATTERN);
	assign path_kinds      = (typ_q == KIND_PATH_PREFIX) || (typ_q == KIND_PATH_EXACT) ||
		(typ_q == KIND_URL_PATTERN);
	assign prefix_kinds    = (typ_q == KIND_PATH_PREFIX) || (typ_q == KIND_URL_PATTERN);

	// Domain check setup ("*." suffix or exact)
	assign wild       = (rdlen_q >= DLEN_W'(2)) && (d0_q == CH_STAR) && (dom_rdata == CH_DOT);
	assign dom_suffix = dom_kinds_wild && wild;
	assign slen       = rdlen_q - DLEN_W'(1);
	always_comb begin
		priority if (dom_suffix)                      dom_fail = (job_q.hlen <= slen);
		else if (dom_kinds_exact || dom_kinds_wild)   dom_fail = (rdlen_q != job_q.hlen);
		else                                          dom_fail = 1'b1;
	end

	// Path check setup ("*" prefix or exact)
	assign pstar     = prefix_kinds && star_q;
	assign pn1       = rplen_q - PLEN_W'(1);
	assign path_fail = pstar ? (job_q.plen < pn1) : (rplen_q != job_q.plen);

	assign cmp_end   = (i_q == clen_q);
	assign byte_eq   = pmode_q ? (pth_rdata == up_rdata) : (dom_rdata == host_rdata);
	assign last_rule = (CNT_W'(r_q) + CNT_W'(1)) == job_q.count;

	// Next state
	always_comb begin
		nxt = state_q;
		unique case (state_q)
			B_IDLE:  if (!q_empty && out_free && head.walk) nxt = B_META;
			B_META:  nxt = B_HDR;
			B_HDR:   nxt = B_HDR2;
			B_HDR2:  nxt = B_HDR3;
			B_HDR3:  nxt = dom_fail ? B_MISS : B_CADDR;
			B_CADDR: begin
				if (cmp_end) nxt = (pmode_q || !path_kinds) ? B_HIT : B_PSET;
				else         nxt = B_CCHK;
			end
			B_CCHK:  nxt = byte_eq ? B_CADDR : B_MISS;
			B_PSET:  nxt = path_fail ? B_MISS : B_CADDR;
			B_MISS:  nxt = last_rule ? B_OUT : B_META;
			B_HIT:   nxt = B_OUT;
			B_OUT:   if (out_free) nxt = B_IDLE;
			default: nxt = B_IDLE;
		endcase
	end

	// Outputs: memory addresses, queue pop, result load
	always_comb begin
		meta_raddr = r_q;
		dom_raddr  = {r_q, DLEN_W'(0)};
		pth_raddr  = {r_q, meta.plen - PLEN_W'(1)};
		host_raddr = DLEN_W'(hoff_q + i_q[DLEN_W-1:0]);
		up_raddr   = i_q;
		q_pop      = 1'b0;
		out_load   = 1'b0;
		walk_done  = 1'b0;
		ld_kind    = 1'b1;
		ld_acc     = 1'b0;
		ld_status  = res_q;
		ld_allowed = (res_q == ST_IN_SCOPE);
		ld_rule    = (res_q == ST_IN_SCOPE) ? 7'(r_q) : NO_RULE;
		unique case (state_q)
			B_IDLE: begin
				q_pop      = !q_empty && out_free;
				out_load   = q_pop && !head.walk;
				ld_kind    = head.is_verdict;
				ld_acc     = head.accepted;
				ld_status  = head.status;
				ld_allowed = head.is_verdict && (head.status == ST_IN_SCOPE);
				ld_rule    = NO_RULE;
			end
			B_HDR2:  dom_raddr = {r_q, DLEN_W'(1)};
			B_CADDR: begin
				dom_raddr = {r_q, DLEN_W'(DLEN_W'(roff_q) + i_q[DLEN_W-1:0])};
				pth_raddr = {r_q, i_q};
			end
			B_OUT: begin
				out_load  = out_free;
				walk_done = out_free;
			end
			default: ;
		endcase
	end

	// Walk datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: if (q_pop) job_q <= head;
			B_HDR: begin
				typ_q   <= meta.kind;
				rdlen_q <= meta.dlen;
				rplen_q <= meta.plen;
			end
			B_HDR2: begin
				d0_q   <= dom_rdata;
				star_q <= (rplen_q != '0) && (pth_rdata == CH_STAR);
			end
			B_HDR3: begin
				i_q     <= '0;
				pmode_q <= 1'b0;
				if (dom_suffix) begin
					clen_q <= PLEN_W'(slen);
					roff_q <= 1'b1;
					hoff_q <= job_q.hlen - slen;
				end else begin
					clen_q <= PLEN_W'(rdlen_q);
					roff_q <= 1'b0;
					hoff_q <= '0;
				end
			end
			B_CCHK: if (byte_eq) i_q <= i_q + PLEN_W'(1);
			B_PSET: begin
				i_q     <= '0;
				pmode_q <= 1'b1;
				clen_q  <= pstar ? pn1 : rplen_q;
			end
			B_MISS: if (last_rule) res_q <= ST_OUT_SCOPE;
			B_HIT:  res_q <= ST_IN_SCOPE;
			default: ;
		endcase
	end

	// Control: state, rule index, result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			r_q       <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= nxt;
			if (state_q == B_IDLE)                  r_q <= '0;
			else if (state_q == B_MISS && !last_rule) r_q <= r_q + RIDX_W'(1);
			if (out_load)       out_vld_q <= 1'b1;
			else if (rsp.ready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_kind_q    <= ld_kind;
			out_acc_q     <= ld_acc;
			out_status_q  <= ld_status;
			out_allowed_q <= ld_allowed;
			out_rule_q    <= ld_rule;
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.result_kind  = out_kind_q;
	assign rsp.accepted     = out_acc_q;
	assign rsp.status       = out_status_q;
	assign rsp.allowed      = out_allowed_q;
	assign rsp.matched_rule = out_rule_q;

endmodule

`default_nettype wire

[hw/rtl/url_scope_rule_matcher.sv]
// url_scope_rule_matcher: top level; front, job queue, back and rule/URL RAMs.
// Depends on usrm_pkg, usrm_in_if, usrm_out_if, usrm_ram, usrm_queue,
// usrm_front, usrm_back.
//
//  channel | dir | beat contents
//  req     | in  | op, data_byte, byte_present, last, rule_kind, approved
//  rsp     | out | result_kind, accepted, status, allowed, matched_rule
//
// The front takes rule bytes, lock, commits and URL bytes while req.ready is high;
// ready drops while the queue is full or a walk holds the URL buffers. A walk
// verdict checks each rule's domain length and bytes, then, for kinds with a path,
// path length and bytes; req stalls from the last URL beat until the result loads.
// Commits and quick verdicts pass through the two-entry queue and out in order.
// Reset clears all control state at once; rule and URL RAMs have no clear pass.
`default_nettype none

module url_scope_rule_matcher import usrm_pkg::*; (
	input wire logic   clk,
	input wire logic   arst_n,
	usrm_in_if.sink    req,
	usrm_out_if.source rsp
);

	logic              q_push, q_pop, q_empty, q_full, walk_done;
	job_t              q_data, q_head;
	front_stat_t       fstat;

	logic              dom_we, pth_we, meta_we, host_we, up_we;
	logic [DOM_AW-1:0] dom_waddr, dom_raddr;
	logic [PTH_AW-1:0] pth_waddr, pth_raddr;
	logic [RIDX_W-1:0] meta_waddr, meta_raddr;
	logic [DLEN_W-1:0] host_waddr, host_raddr;
	logic [PLEN_W-1:0] up_waddr, up_raddr;
	logic [7:0]        dom_wdata, pth_wdata, host_wdata, up_wdata;
	logic [7:0]        dom_rdata, pth_rdata, host_rdata, up_rdata;
	meta_t             meta_wdata;
	logic [META_W-1:0] meta_rdata;

	usrm_front u_front (
		.clk, .arst_n, .req,
		.q_full, .q_push, .q_data, .walk_done,
		.dom_we, .dom_waddr, .dom_wdata,
		.pth_we, .pth_waddr, .pth_wdata,
		.meta_we, .meta_waddr, .meta_wdata,
		.host_we, .host_waddr, .host_wdata,
		.up_we, .up_waddr, .up_wdata,
		.stat(fstat)
	);

	usrm_queue u_queue (
		.clk, .arst_n,
		.push(q_push), .push_data(q_data),
		.pop(q_pop), .head(q_head), .empty(q_empty), .full(q_full)
	);

	usrm_back u_back (
		.clk, .arst_n,
		.head(q_head), .q_empty, .q_pop, .walk_done,
		.meta_raddr, .meta_rdata,
		.dom_raddr, .dom_rdata,
		.pth_raddr, .pth_rdata,
		.host_raddr, .host_rdata,
		.up_raddr, .up_rdata,
		.rsp
	);

	usrm_ram #(.WIDTH(META_W), .DEPTH(META_DEPTH)) u_meta_ram (
		.clk, .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
		.raddr(meta_raddr), .rdata(meta_rdata)
	);

	usrm_ram #(.WIDTH(8), .DEPTH(DOM_DEPTH)) u_dom_ram (
		.clk, .we(dom_we), .waddr(dom_waddr), .wdata(dom_wdata),
		.raddr(dom_raddr), .rdata(dom_rdata)
	);

	usrm_ram #(.WIDTH(8), .DEPTH(PTH_DEPTH)) u_pth_ram (
		.clk, .we(pth_we), .waddr(pth_waddr), .wdata(pth_wdata),
		.raddr(pth_raddr), .rdata(pth_rdata)
	);

	usrm_ram #(.WIDTH(8), .DEPTH(HOST_DEPTH)) u_host_ram (
		.clk, .we(host_we), .waddr(host_waddr), .wdata(host_wdata),
		.raddr(host_raddr), .rdata(host_rdata)
	);

	usrm_ram #(.WIDTH(8), .DEPTH(UP_DEPTH)) u_up_ram (
		.clk, .we(up_we), .waddr(up_waddr), .wdata(up_wdata),
		.raddr(up_raddr), .rdata(up_rdata)
	);

	// A walk only finishes while the front holds the URL buffers
	a_walk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		walk_done |-> fstat.busy)
		else $error("walk finished without a held URL");

	// Front never takes a beat into a full queue
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !req.ready)
		else $error("request accepted with job queue full");

	// Rule count stays within the table
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fstat.count <= CNT_W'(RULES))
		else $error("rule count beyond table size");

endmodule

`default_nettype wire
